/* sv/plq_pkg.sv */
// shared types and constants for the price level order queue
package plq_pkg;

  localparam int ID_W     = 10;
  localparam int PRICE_W  = 32;
  localparam int SHARES_W = 32;
  localparam int COUNT_W  = 11;
  localparam int SIZE_W   = 42;
  localparam int VOL_W    = 64;

  // request codes
  localparam logic [1:0] REQ_PUSH   = 2'd0;
  localparam logic [1:0] REQ_POP    = 2'd1;
  localparam logic [1:0] REQ_CANCEL = 2'd2;
  localparam logic [1:0] REQ_NOP    = 2'd3;

  // status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_PRICE = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_ID    = 2'd3;

  // saturation limits, in the width of the shared unit
  localparam logic [VOL_W-1:0] SIZE_LIMIT = {{(VOL_W-SIZE_W){1'b0}}, {SIZE_W{1'b1}}};
  localparam logic [VOL_W-1:0] VOL_LIMIT  = {VOL_W{1'b1}};

  typedef struct packed {
    logic [1:0]          req_type;
    logic [ID_W-1:0]     order_id;
    logic [PRICE_W-1:0]  order_price;
    logic [SHARES_W-1:0] order_shares;
  } req_item_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [ID_W-1:0]     popped_id;
    logic [SHARES_W-1:0] popped_shares;
    logic [COUNT_W-1:0]  order_count;
    logic [SIZE_W-1:0]   level_size;
    logic [VOL_W-1:0]    level_volume;
  } rsp_item_t;

  typedef enum logic [1:0] {
    ALU_MUL = 2'd0,
    ALU_ADD = 2'd1,
    ALU_SUB = 2'd2
  } alu_op_t;

  // write strobes into the slot pool
  typedef struct packed {
    logic next_we;
    logic prev_we;
    logic shares_we;
    logic used_we;
    logic used_val;
  } pool_wr_t;

endpackage

/* sv/plq_chan_if.sv */
// valid/ready channel carrying one payload struct
interface plq_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/price_level_order_queue_unit.sv */
// top level: one price level of an order book as a linked fifo over a slot pool
//
//   channel   dir   handshake          payload
//   in_req    in    valid / ready      req_type, order_id, order_price, order_shares
//   out_rsp   out   valid / ready      status, popped_id, popped_shares, order_count,
//                                      level_size, level_volume
//   cfg       in    cfg_we             cfg_wdata = level price
//
// a pop or cancel steps read, evaluate, multiply, size, volume, done; a push adds
// a back-link write after evaluate; a rejected or no-op request skips to done;
// the single registered pool read and the three shared-unit passes set these steps
// after reset the in-use memory is swept entry by entry, with in_req not ready
// the result sits in an output register, so the next request is accepted while it
// waits; a request only stalls at its last step if the previous result is still held
module price_level_order_queue_unit import plq_pkg::*; #(
  parameter int POOL_ENTRIES = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  plq_chan_if.sink            in_req,
  plq_chan_if.source          out_rsp,
  input  logic                cfg_we,
  input  logic [PRICE_W-1:0]  cfg_wdata
);

  localparam int AW = $clog2(POOL_ENTRIES);
  localparam int LW = $clog2(POOL_ENTRIES + 1);
  localparam logic [LW-1:0] NIL = LW'(POOL_ENTRIES);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_READ  = 8'b0000_0010,
    S_EVAL  = 8'b0000_0100,
    S_LINK2 = 8'b0000_1000,
    S_MUL   = 8'b0001_0000,
    S_SIZE  = 8'b0010_0000,
    S_VOL   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t              state_r, state_nxt;
  logic [1:0]          req_type_r, req_type_nxt;
  logic [ID_W-1:0]     req_id_r, req_id_nxt;
  logic [PRICE_W-1:0]  req_price_r, req_price_nxt;
  logic [SHARES_W-1:0] req_shares_r, req_shares_nxt;
  logic [PRICE_W-1:0]  price_r;
  logic [LW-1:0]       head_r, head_nxt;
  logic [LW-1:0]       tail_r, tail_nxt;
  logic [LW-1:0]       count_r, count_nxt;
  logic [SIZE_W-1:0]   size_r, size_nxt;
  logic [VOL_W-1:0]    vol_r, vol_nxt;
  logic [SHARES_W-1:0] work_shares_r, work_shares_nxt;
  logic [VOL_W-1:0]    prod_r, prod_nxt;
  logic                removing_r, removing_nxt;
  logic [1:0]          status_r, status_nxt;
  logic [ID_W-1:0]     pop_id_r, pop_id_nxt;
  logic [SHARES_W-1:0] pop_shares_r, pop_shares_nxt;
  logic                out_valid_r, out_valid_nxt;
  rsp_item_t           out_data_r, out_data_nxt;

  // pool and shared unit hookup
  logic                pool_busy;
  logic [AW-1:0]       rd_addr;
  logic [LW-1:0]       next_q, prev_q;
  logic [SHARES_W-1:0] shares_q;
  logic                used_q;
  pool_wr_t            pool_wr;
  logic [AW-1:0]       next_addr, prev_addr, slot_addr;
  logic [LW-1:0]       next_data, prev_data;
  logic [SHARES_W-1:0] shares_data;

  alu_op_t             alu_op;
  logic [VOL_W-1:0]    alu_a, alu_b, alu_limit, alu_y;

  logic                in_ready;
  logic                id_ok;
  logic [AW-1:0]       id_addr;
  logic [LW-1:0]       id_link;
  logic [LW-1:0]       victim;

  assign in_ready      = (state_r == S_IDLE) && !pool_busy;
  assign in_req.ready  = in_ready;
  assign out_rsp.valid = out_valid_r;
  assign out_rsp.data  = out_data_r;

  // ids past the pool end are rejected before any memory write
  assign id_ok   = {{(32-ID_W){1'b0}}, req_id_r} < 32'(POOL_ENTRIES);
  assign id_addr = AW'(req_id_r);
  assign id_link = LW'(req_id_r);
  // slot being unlinked: oldest order for a pop, named order for a cancel
  assign victim  = (req_type_r == REQ_POP) ? tail_r : id_link;
  assign rd_addr = (req_type_r == REQ_POP) ? tail_r[AW-1:0] : id_addr;

  plq_pool #(
    .POOL_ENTRIES(POOL_ENTRIES)
  ) u_pool (
    .clk        (clk),
    .rst_n      (rst_n),
    .busy       (pool_busy),
    .rd_addr    (rd_addr),
    .next_q     (next_q),
    .prev_q     (prev_q),
    .shares_q   (shares_q),
    .used_q     (used_q),
    .wr         (pool_wr),
    .next_addr  (next_addr),
    .next_data  (next_data),
    .prev_addr  (prev_addr),
    .prev_data  (prev_data),
    .slot_addr  (slot_addr),
    .shares_data(shares_data)
  );

  plq_alu u_alu (
    .op   (alu_op),
    .a    (alu_a),
    .b    (alu_b),
    .limit(alu_limit),
    .y    (alu_y)
  );

  always_comb begin
    state_nxt       = state_r;
    req_type_nxt    = req_type_r;
    req_id_nxt      = req_id_r;
    req_price_nxt   = req_price_r;
    req_shares_nxt  = req_shares_r;
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    count_nxt       = count_r;
    size_nxt        = size_r;
    vol_nxt         = vol_r;
    work_shares_nxt = work_shares_r;
    prod_nxt        = prod_r;
    removing_nxt    = removing_r;
    status_nxt      = status_r;
    pop_id_nxt      = pop_id_r;
    pop_shares_nxt  = pop_shares_r;
    out_valid_nxt   = out_valid_r && !out_rsp.ready;
    out_data_nxt    = out_data_r;

    pool_wr     = '0;
    next_addr   = '0;
    next_data   = '0;
    prev_addr   = '0;
    prev_data   = '0;
    slot_addr   = '0;
    shares_data = '0;

    alu_op    = ALU_MUL;
    alu_a     = '0;
    alu_b     = '0;
    alu_limit = VOL_LIMIT;

    case (state_r)
      S_IDLE: begin
        if (in_req.valid && in_ready) begin
          req_type_nxt   = in_req.data.req_type;
          req_id_nxt     = in_req.data.order_id;
          req_price_nxt  = in_req.data.order_price;
          req_shares_nxt = in_req.data.order_shares;
          status_nxt     = ST_DONE;
          pop_id_nxt     = '0;
          pop_shares_nxt = '0;
          state_nxt      = S_READ;
        end
      end

      // pool read is in flight
      S_READ: begin
        state_nxt = S_EVAL;
      end

      S_EVAL: begin
        state_nxt = S_DONE;
        case (req_type_r)
          REQ_PUSH: begin
            if (req_price_r != price_r) begin
              status_nxt = ST_PRICE;
            end else if (!id_ok || used_q) begin
              status_nxt = ST_ID;
            end else begin
              // new slot points at the old head, nothing before it
              pool_wr.next_we   = 1'b1;
              pool_wr.prev_we   = 1'b1;
              pool_wr.shares_we = 1'b1;
              pool_wr.used_we   = 1'b1;
              pool_wr.used_val  = 1'b1;
              next_addr         = id_addr;
              next_data         = head_r;
              prev_addr         = id_addr;
              prev_data         = NIL;
              slot_addr         = id_addr;
              shares_data       = req_shares_r;
              count_nxt         = count_r + 1'b1;
              work_shares_nxt   = req_shares_r;
              removing_nxt      = 1'b0;
              state_nxt         = S_LINK2;
            end
          end
          REQ_POP, REQ_CANCEL: begin
            if ((req_type_r == REQ_POP) && (tail_r == NIL)) begin
              status_nxt = ST_EMPTY;
            end else if ((req_type_r == REQ_CANCEL) && (!id_ok || !used_q)) begin
              status_nxt = ST_ID;
            end else begin
              pop_id_nxt      = ID_W'(victim);
              pop_shares_nxt  = shares_q;
              work_shares_nxt = shares_q;
              // bridge the neighbours around the victim
              if (prev_q != NIL) begin
                pool_wr.next_we = 1'b1;
                next_addr       = prev_q[AW-1:0];
                next_data       = next_q;
              end else begin
                head_nxt = next_q;
              end
              if (next_q != NIL) begin
                pool_wr.prev_we = 1'b1;
                prev_addr       = next_q[AW-1:0];
                prev_data       = prev_q;
              end else begin
                tail_nxt = prev_q;
              end
              pool_wr.used_we  = 1'b1;
              pool_wr.used_val = 1'b0;
              slot_addr        = victim[AW-1:0];
              count_nxt        = (count_r != '0) ? count_r - 1'b1 : count_r;
              removing_nxt     = 1'b1;
              state_nxt        = S_MUL;
            end
          end
          default: begin
            status_nxt = ST_DONE;
          end
        endcase
      end

      // back link from the old head, second write to the prev memory
      S_LINK2: begin
        if (head_r != NIL) begin
          pool_wr.prev_we = 1'b1;
          prev_addr       = head_r[AW-1:0];
          prev_data       = id_link;
        end else begin
          tail_nxt = id_link;
        end
        head_nxt  = id_link;
        state_nxt = S_MUL;
      end

      S_MUL: begin
        alu_op    = ALU_MUL;
        alu_a     = VOL_W'(work_shares_r);
        alu_b     = VOL_W'(price_r);
        prod_nxt  = alu_y;
        state_nxt = S_SIZE;
      end

      S_SIZE: begin
        alu_op    = removing_r ? ALU_SUB : ALU_ADD;
        alu_a     = VOL_W'(size_r);
        alu_b     = VOL_W'(work_shares_r);
        alu_limit = SIZE_LIMIT;
        size_nxt  = alu_y[SIZE_W-1:0];
        state_nxt = S_VOL;
      end

      S_VOL: begin
        alu_op    = removing_r ? ALU_SUB : ALU_ADD;
        alu_a     = vol_r;
        alu_b     = prod_r;
        alu_limit = VOL_LIMIT;
        vol_nxt   = alu_y;
        // last order gone: the level is flat again
        if (removing_r && (count_r == '0)) begin
          size_nxt = '0;
          vol_nxt  = '0;
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.status        = status_r;
          out_data_nxt.popped_id     = pop_id_r;
          out_data_nxt.popped_shares = pop_shares_r;
          out_data_nxt.order_count   = COUNT_W'(count_r);
          out_data_nxt.level_size    = size_r;
          out_data_nxt.level_volume  = vol_r;
          state_nxt                  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      price_r     <= '0;
      head_r      <= NIL;
      tail_r      <= NIL;
      count_r     <= '0;
      size_r      <= '0;
      vol_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      size_r      <= size_nxt;
      vol_r       <= vol_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        price_r <= cfg_wdata;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    req_type_r    <= req_type_nxt;
    req_id_r      <= req_id_nxt;
    req_price_r   <= req_price_nxt;
    req_shares_r  <= req_shares_nxt;
    work_shares_r <= work_shares_nxt;
    prod_r        <= prod_nxt;
    removing_r    <= removing_nxt;
    status_r      <= status_nxt;
    pop_id_r      <= pop_id_nxt;
    pop_shares_r  <= pop_shares_nxt;
    out_data_r    <= out_data_nxt;
  end

`ifndef SYNTHESIS
  // an empty level has no head, a resting order always has one
  a_count_head: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ((count_r == '0) == (head_r == NIL)))
    else $error("order count and head pointer disagree");

  // both list ends are null together
  a_head_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ((head_r == NIL) == (tail_r == NIL)))
    else $error("head and tail pointers disagree on empty");

  // an empty level carries no size or volume
  a_empty_flat: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_IDLE) && (count_r == '0)) |-> ((size_r == '0) && (vol_r == '0)))
    else $error("empty level with nonzero size or volume");

  // a result only appears from the final step of a request
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside the final step");
`endif

endmodule

/* sv/plq_alu.sv */
// shared multiply / saturating add / floored subtract unit
module plq_alu import plq_pkg::*; (
  input  alu_op_t          op,
  input  logic [VOL_W-1:0] a,
  input  logic [VOL_W-1:0] b,
  input  logic [VOL_W-1:0] limit,
  output logic [VOL_W-1:0] y
);

  logic [VOL_W-1:0] mul_y;
  logic [VOL_W:0]   sum;

  assign mul_y = a[31:0] * b[31:0];
  assign sum   = {1'b0, a} + {1'b0, b};

  always_comb begin
    case (op)
      ALU_MUL: y = mul_y;
      ALU_ADD: y = (sum > {1'b0, limit}) ? limit : sum[VOL_W-1:0];
      ALU_SUB: y = (a > b) ? (a - b) : '0;
      default: y = '0;
    endcase
  end

endmodule

/* sv/plq_pool.sv */
// order slot pool: link, share and in-use memories with post-reset clear
module plq_pool import plq_pkg::*; #(
  parameter  int POOL_ENTRIES = 1024,
  localparam int AW = $clog2(POOL_ENTRIES),
  localparam int LW = $clog2(POOL_ENTRIES + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  output logic                busy,
  input  logic [AW-1:0]       rd_addr,
  output logic [LW-1:0]       next_q,
  output logic [LW-1:0]       prev_q,
  output logic [SHARES_W-1:0] shares_q,
  output logic                used_q,
  input  pool_wr_t            wr,
  input  logic [AW-1:0]       next_addr,
  input  logic [LW-1:0]       next_data,
  input  logic [AW-1:0]       prev_addr,
  input  logic [LW-1:0]       prev_data,
  input  logic [AW-1:0]       slot_addr,
  input  logic [SHARES_W-1:0] shares_data
);

  logic [LW-1:0]       next_mem   [POOL_ENTRIES];
  logic [LW-1:0]       prev_mem   [POOL_ENTRIES];
  logic [SHARES_W-1:0] shares_mem [POOL_ENTRIES];
  logic                used_mem   [POOL_ENTRIES];

  logic          busy_r;
  logic [AW-1:0] clr_addr_r;

  assign busy = busy_r;

  // in-use clearing sweep, one entry per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      clr_addr_r <= '0;
    end else if (busy_r) begin
      if (clr_addr_r == AW'(POOL_ENTRIES - 1)) begin
        busy_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.next_we) begin
      next_mem[next_addr] <= next_data;
    end
    next_q <= next_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr.prev_we) begin
      prev_mem[prev_addr] <= prev_data;
    end
    prev_q <= prev_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr.shares_we) begin
      shares_mem[slot_addr] <= shares_data;
    end
    shares_q <= shares_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      used_mem[clr_addr_r] <= 1'b0;
    end else if (wr.used_we) begin
      used_mem[slot_addr] <= wr.used_val;
    end
    used_q <= used_mem[rd_addr];
  end

endmodule

/* verif/price_level_order_queue_unit_tb.sv */
// self-checking testbench for the price level order queue with its own linked-list predictor
module price_level_order_queue_unit_tb import plq_pkg::*; ();

  localparam int POOL_N         = 1024;
  localparam int NIL_SLOT       = POOL_N;   // empty link, as in the block
  localparam int LONG_HOLD      = 400;      // receiver back-pressure stretch
  localparam int WATCHDOG_LIMIT = 4000;     // covers the post-reset sweep and the long hold
  localparam int TAIL_CYCLES    = 20;
  localparam int MAX_REPORTS    = 40;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [PRICE_W-1:0] cfg_wdata;

  plq_chan_if #(.payload_t(req_item_t)) in_req ();
  plq_chan_if #(.payload_t(rsp_item_t)) out_rsp ();

  price_level_order_queue_unit #(
    .POOL_ENTRIES(POOL_N)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_req),
    .out_rsp  (out_rsp),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // 10 time unit clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------
  // predicted book: doubly linked fifo over the slot pool
  // ---------------------------------------------------------------
  logic [PRICE_W-1:0]  book_price = '0;
  int                  link_next [POOL_N];
  int                  link_prev [POOL_N];
  logic [SHARES_W-1:0] slot_qty  [POOL_N];
  bit                  slot_used [POOL_N];
  int                  head_id = NIL_SLOT;   // newest order
  int                  tail_id = NIL_SLOT;   // oldest order
  logic [COUNT_W-1:0]  rest_count  = '0;
  logic [VOL_W-1:0]    rest_size   = '0;     // kept wide, saturates at SIZE_LIMIT
  logic [VOL_W-1:0]    rest_volume = '0;

  // request traffic and expected level reports
  req_item_t request_backlog [$];
  rsp_item_t awaited_reports [$];

  // pacing controls, set by the stimulus sequence
  bit sender_calm   = 1'b0;
  bit receiver_calm = 1'b0;
  int hold_req      = 0;
  int hold_ack      = 0;
  int send_gap      = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  // bookkeeping
  int mismatches      = 0;
  int requests_sent   = 0;
  int reports_checked = 0;
  int status_seen [4] = '{default: 0};
  int peak_count      = 0;
  int saturated_seen  = 0;
  int price_settings  = 0;

  // unlink one resting order and take it off the level totals
  function automatic void drop_order(int s);
    int               p;
    int               n;
    logic [VOL_W-1:0] notional;
    logic [VOL_W-1:0] qty;
    p = link_prev[s];
    n = link_next[s];
    if (p != NIL_SLOT) begin
      link_next[p] = n;
    end else begin
      head_id = n;
    end
    if (n != NIL_SLOT) begin
      link_prev[n] = p;
    end else begin
      tail_id = p;
    end
    slot_used[s] = 1'b0;
    // removal is priced at the current level price, floored at zero
    qty      = VOL_W'(slot_qty[s]);
    notional = qty * VOL_W'(book_price);
    if (rest_count > 0) rest_count = rest_count - 1'b1;
    rest_size   = (rest_size > qty) ? rest_size - qty : '0;
    rest_volume = (rest_volume > notional) ? rest_volume - notional : '0;
    if (rest_count == 0) begin
      rest_size   = '0;
      rest_volume = '0;
    end
  endfunction

  // apply one request to the predicted book and build the expected report
  function automatic rsp_item_t level_apply(req_item_t r);
    rsp_item_t        res;
    int               id;
    logic [VOL_W-1:0] notional;
    logic [VOL_W:0]   vol_sum;
    res        = '0;
    res.status = ST_DONE;
    id         = int'(r.order_id);
    case (r.req_type)
      REQ_PUSH: begin
        if (r.order_price != book_price) begin
          res.status = ST_PRICE;
        end else if (id >= NIL_SLOT || slot_used[id]) begin
          res.status = ST_ID;
        end else begin
          // new order goes in at the head
          link_next[id] = head_id;
          link_prev[id] = NIL_SLOT;
          if (head_id != NIL_SLOT) begin
            link_prev[head_id] = id;
          end else begin
            tail_id = id;
          end
          head_id       = id;
          slot_qty[id]  = r.order_shares;
          slot_used[id] = 1'b1;
          rest_count    = rest_count + 1'b1;
          rest_size     = rest_size + VOL_W'(r.order_shares);
          if (rest_size > SIZE_LIMIT) rest_size = SIZE_LIMIT;
          notional    = VOL_W'(r.order_shares) * VOL_W'(book_price);
          vol_sum     = {1'b0, rest_volume} + {1'b0, notional};
          rest_volume = vol_sum[VOL_W] ? VOL_LIMIT : vol_sum[VOL_W-1:0];
        end
      end
      REQ_POP: begin
        if (tail_id == NIL_SLOT) begin
          res.status = ST_EMPTY;
        end else begin
          res.popped_id     = ID_W'(tail_id);
          res.popped_shares = slot_qty[tail_id];
          drop_order(tail_id);
        end
      end
      REQ_CANCEL: begin
        if (id >= NIL_SLOT || !slot_used[id]) begin
          res.status = ST_ID;
        end else begin
          res.popped_id     = r.order_id;
          res.popped_shares = slot_qty[id];
          drop_order(id);
        end
      end
      default: begin
        // no-op request leaves the book alone
      end
    endcase
    res.order_count  = rest_count;
    res.level_size   = rest_size[SIZE_W-1:0];
    res.level_volume = rest_volume;
    return res;
  endfunction

  // ---------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------
  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic check_report(rsp_item_t got, rsp_item_t want);
    if (got.status !== want.status)
      report_mismatch($sformatf("report %0d status got %0d want %0d",
                                reports_checked, got.status, want.status));
    if (got.popped_id !== want.popped_id)
      report_mismatch($sformatf("report %0d popped_id got %0d want %0d",
                                reports_checked, got.popped_id, want.popped_id));
    if (got.popped_shares !== want.popped_shares)
      report_mismatch($sformatf("report %0d popped_shares got %0h want %0h",
                                reports_checked, got.popped_shares, want.popped_shares));
    if (got.order_count !== want.order_count)
      report_mismatch($sformatf("report %0d order_count got %0d want %0d",
                                reports_checked, got.order_count, want.order_count));
    if (got.level_size !== want.level_size)
      report_mismatch($sformatf("report %0d level_size got %0h want %0h",
                                reports_checked, got.level_size, want.level_size));
    if (got.level_volume !== want.level_volume)
      report_mismatch($sformatf("report %0d level_volume got %0h want %0h",
                                reports_checked, got.level_volume, want.level_volume));
  endtask

  // ---------------------------------------------------------------
  // random helpers
  // ---------------------------------------------------------------

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap(bit calm);
    int roll;
    roll = $urandom_range(99);
    if (calm || roll < 55) return 0;
    if (roll < 85) return $urandom_range(4, 1);
    if (roll < 97) return $urandom_range(15, 5);
    return $urandom_range(90, 30);
  endfunction

  function automatic logic [SHARES_W-1:0] pick_shares();
    int sel;
    sel = $urandom_range(9);
    if (sel < 2) return '1;
    if (sel == 2) return '0;
    if (sel < 6) return SHARES_W'($urandom_range(1000, 1));
    return $urandom;
  endfunction

  function automatic req_item_t make_req(logic [1:0] kind, int id, logic [PRICE_W-1:0] price,
                                         logic [SHARES_W-1:0] qty);
    req_item_t r;
    r.req_type     = kind;
    r.order_id     = ID_W'(id);
    r.order_price  = price;
    r.order_shares = qty;
    return r;
  endfunction

  // mixed traffic: ids mostly from a narrow window so pushes and cancels collide,
  // prices mostly matching the level
  function automatic req_item_t random_request(int id_hi, int push_pct);
    req_item_t r;
    int        pick;
    pick = $urandom_range(99);
    if (pick < push_pct) begin
      r.req_type = REQ_PUSH;
    end else if (pick < push_pct + 25) begin
      r.req_type = REQ_POP;
    end else if (pick < 95) begin
      r.req_type = REQ_CANCEL;
    end else begin
      r.req_type = REQ_NOP;
    end
    r.order_id     = ($urandom_range(9) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(id_hi));
    r.order_price  = ($urandom_range(7) == 0) ? PRICE_W'($urandom) : book_price;
    r.order_shares = pick_shares();
    return r;
  endfunction

  // sender holds off until every request has been answered
  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (request_backlog.size() != 0 || in_req.valid || awaited_reports.size() != 0);
  endtask

  // level price write, only with the block idle
  task automatic set_price(logic [PRICE_W-1:0] v);
    wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we     <= 1'b0;
    book_price  = v;
    price_settings++;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------
  // request driver: pulls from the backlog, random gaps between requests
  // ---------------------------------------------------------------
  always @(posedge clk) begin : req_driver
    if (!rst_n) begin
      in_req.valid <= 1'b0;
      send_gap      = 0;
    end else begin
      // predict at the accepting edge
      if (in_req.valid && in_req.ready) begin
        awaited_reports.push_back(level_apply(in_req.data));
        requests_sent++;
      end
      if (!in_req.valid || in_req.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_req.valid <= 1'b0;
        end else if (request_backlog.size() > 0) begin
          in_req.data  <= request_backlog.pop_front();
          in_req.valid <= 1'b1;
          send_gap      = pick_gap(sender_calm);
        end else begin
          in_req.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // report monitor: random ready stalls, long hold on request, compares in order
  // ---------------------------------------------------------------
  always @(posedge clk) begin : rsp_monitor
    rsp_item_t want;
    if (!rst_n) begin
      out_rsp.ready <= 1'b0;
      hold_left      = 0;
    end else begin
      if (out_rsp.valid && out_rsp.ready) begin
        if (awaited_reports.size() == 0) begin
          report_mismatch($sformatf("report with nothing expected, status %0d id %0d",
                                    out_rsp.data.status, out_rsp.data.popped_id));
        end else begin
          want = awaited_reports.pop_front();
          check_report(out_rsp.data, want);
          status_seen[want.status]++;
          if (int'(want.order_count) > peak_count) peak_count = int'(want.order_count);
          if (want.level_volume == VOL_LIMIT) saturated_seen++;
        end
        reports_checked++;
        hold_left = pick_gap(receiver_calm);
      end
      // long back-pressure so the block fills and stalls its input
      if (hold_ack != hold_req) begin
        hold_ack  = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_rsp.ready <= 1'b0;
      end else begin
        out_rsp.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------
  // watchdog: no handshake on either channel for too long
  // ---------------------------------------------------------------
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog: no handshake for %0d cycles, %0d reports outstanding",
               $time, quiet_cycles, awaited_reports.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------
  // stimulus sequence
  // ---------------------------------------------------------------
  initial begin : stimulus
    int order_ids [POOL_N];
    int j;
    int tmp;
    int id_hi;

    // every input known from time zero
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_req.valid  = 1'b0;
    in_req.data   = '0;
    out_rsp.ready = 1'b0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part at the top price: saturation and every rejection
    set_price('1);
    request_backlog.push_back(make_req(REQ_POP, 0, '1, '1));                 // pop of empty level
    request_backlog.push_back(make_req(REQ_CANCEL, 0, '0, '0));              // cancel absent id
    request_backlog.push_back(make_req(REQ_NOP, 1023, $urandom, $urandom));  // no-op
    request_backlog.push_back(make_req(REQ_PUSH, 7, '0, '1));                // price mismatch
    request_backlog.push_back(make_req(REQ_PUSH, 0, '1, '1));                // largest notional
    request_backlog.push_back(make_req(REQ_PUSH, 1023, '1, '1));             // volume saturates
    request_backlog.push_back(make_req(REQ_PUSH, 0, '1, 5));                 // id busy
    request_backlog.push_back(make_req(REQ_PUSH, 512, '1, '0));              // zero shares
    request_backlog.push_back(make_req(REQ_PUSH, 341, '1, 1));
    request_backlog.push_back(make_req(REQ_CANCEL, 1023, '0, '0));           // cancel mid-list
    request_backlog.push_back(make_req(REQ_CANCEL, 1023, '1, '1));           // now absent
    request_backlog.push_back(make_req(REQ_POP, 682, '0, '0));               // oldest is id 0
    request_backlog.push_back(make_req(REQ_POP, 0, '0, '0));                 // then id 512
    request_backlog.push_back(make_req(REQ_CANCEL, 341, '0, '0));            // last order leaves
    request_backlog.push_back(make_req(REQ_POP, 0, '0, '0));                 // empty again
    request_backlog.push_back(make_req(REQ_NOP, 0, '0, '0));
    request_backlog.push_back(make_req(REQ_PUSH, 682, 32'hFFFF_FFFE, 5));    // price one off
    // zero price: volume stays zero whatever the shares
    set_price('0);
    request_backlog.push_back(make_req(REQ_PUSH, 1, '0, '1));
    request_backlog.push_back(make_req(REQ_PUSH, 2, '0, 3));
    request_backlog.push_back(make_req(REQ_POP, 0, '1, '1));

    // random phases over several level prices, orders left resting across changes
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_price($urandom);
        1: set_price('0);
        2: set_price(32'd1);
        3: set_price('1);
        default: set_price($urandom_range(5000, 1));
      endcase
      sender_calm   = (ph == 2);
      receiver_calm = (ph == 2);
      id_hi = (ph % 3 == 0) ? 15 : (ph % 3 == 1) ? 63 : 1023;
      repeat (90) request_backlog.push_back(random_request(id_hi, 40));
    end
    sender_calm   = 1'b0;
    receiver_calm = 1'b0;

    // empty the level, then fill the whole pool in shuffled id order
    set_price(32'd1000);
    repeat (int'(rest_count)) request_backlog.push_back(make_req(REQ_POP, $urandom, '0, '0));
    for (int k = 0; k < POOL_N; k++) order_ids[k] = k;
    for (int k = POOL_N - 1; k > 0; k--) begin
      j            = $urandom_range(k);
      tmp          = order_ids[k];
      order_ids[k] = order_ids[j];
      order_ids[j] = tmp;
    end
    for (int k = 0; k < POOL_N; k++)
      request_backlog.push_back(make_req(REQ_PUSH, order_ids[k], book_price, pick_shares()));
    // receiver stalls while the sender keeps offering
    hold_req++;
    repeat (120) request_backlog.push_back(random_request(1023, 10));

    // raise the price under resting orders so removals hit the zero floor
    set_price('1);
    repeat (150) request_backlog.push_back(random_request(1023, 10));

    // drain and let the pipeline settle
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d requests over %0d level prices: %0d done, %0d price rejects,",
             requests_sent, price_settings, status_seen[ST_DONE], status_seen[ST_PRICE]);
    $display("%0d empty pops, %0d id rejects, deepest level %0d orders, %0d saturated volumes",
             status_seen[ST_EMPTY], status_seen[ST_ID], peak_count, saturated_seen);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
